>>> rtl/core/tclru_pkg.sv
`timescale 1ns / 1ps

package tclru_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int MAX_ZOOM   = 18;

  localparam int SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OP_W     = 2;
  localparam int ZOOM_W   = 5;
  localparam int COORD_W  = 20;
  localparam int POS_W    = MAX_ZOOM;
  localparam int SEL_W    = 6;
  localparam int STAMP_W  = 64;

  localparam logic [OP_W-1:0] OP_LOOKUP      = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_READY   = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_LOADING = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic [ZOOM_W-1:0]         zoom_level;
    logic signed [COORD_W-1:0] tile_col;
    logic signed [COORD_W-1:0] tile_row;
    logic [SEL_W-1:0]          slot_sel;
    logic                      flag_value;
  } in_item_t;

  typedef struct packed {
    logic             in_range;
    logic             hit;
    logic [SEL_W-1:0] slot;
    logic             evict_ready;
    logic             entry_ready;
    logic             entry_loading;
    logic             parent_hit;
    logic [SEL_W-1:0] parent_slot;
  } out_item_t;

  typedef struct packed {
    logic [ZOOM_W-1:0]  zoom;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               ready;
    logic               loading;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic              load_req;
    logic              scan_clear;
    logic              scan_rd;
    logic [SLOT_W-1:0] scan_idx;
    logic              set_rd;
    logic              commit_lookup;
    logic              commit_set;
    logic              commit_empty;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_range;
    logic            sel_ok;
    logic            out_free;
  } dp_status_t;

endpackage

>>> rtl/core/tile_cache_lru_lookup_core.sv
`timescale 1ns / 1ps
// Fully associative tile cache with least-recently-used replacement.
// Input channel (in_valid/in_ready/in_data): one operation per transfer,
// a lookup by zoom, column and row, or a write of the ready or loading
// flag of one slot. Result channel (out_valid/out_ready/out_data): one
// result per operation, in order.
// A lookup reads every slot of the entry RAM once, one slot per cycle
// through its single read port, to find the match, the victim and a
// ready parent tile, then writes its result to the output register in
// the commit step; a new item is taken in the cycle after that. A flag
// write takes one read and one write of the RAM. Out-of-range lookups
// and unused opcodes do not touch the RAM.
// A result waits in an output register; the block takes the next item
// meanwhile, runs it, and holds in its commit step until the register
// is free. rst_n (synchronous, active low) clears all valid bits and the
// use counter; the block accepts items in the cycle after reset.
module tile_cache_lru_lookup_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tclru_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tclru_pkg::out_item_t out_data
);

  tclru_pkg::dp_cmd_t    cmd;
  tclru_pkg::dp_status_t status;

  tclru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tclru_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

>>> rtl/core/tclru_ram.sv
`timescale 1ns / 1ps

module tclru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/tclru_ctrl.sv
`timescale 1ns / 1ps

module tclru_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tclru_pkg::dp_status_t status,
  output tclru_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_SET_RD,
    ST_SET_WR,
    ST_EMPTY
  } state_t;

  localparam logic [tclru_pkg::SLOT_W-1:0] LAST_IDX =
    tclru_pkg::SLOT_W'(tclru_pkg::SLOT_COUNT - 1);

  state_t                       state_r, state_nxt;
  logic [tclru_pkg::SLOT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.scan_idx = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        // hold off transfers while reset is asserted
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cnt_nxt = '0;
        priority if (status.op == tclru_pkg::OP_LOOKUP && status.in_range) begin
          cmd.scan_clear = 1'b1;
          state_nxt      = ST_SCAN;
        end else if ((status.op == tclru_pkg::OP_SET_READY ||
                      status.op == tclru_pkg::OP_SET_LOADING) && status.sel_ok) begin
          state_nxt = ST_SET_RD;
        end else begin
          state_nxt = ST_EMPTY;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit_lookup = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_SET_RD: begin
        cmd.set_rd = 1'b1;
        state_nxt  = ST_SET_WR;
      end
      ST_SET_WR: begin
        if (status.out_free) begin
          cmd.commit_set = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          cmd.commit_empty = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/tclru_dpath.sv
`timescale 1ns / 1ps

module tclru_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tclru_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tclru_pkg::out_item_t  out_data,
  input  tclru_pkg::dp_cmd_t    cmd,
  output tclru_pkg::dp_status_t status
);

  localparam int SW = tclru_pkg::SLOT_W;
  localparam int PW = tclru_pkg::POS_W;
  localparam int ZW = tclru_pkg::ZOOM_W;

  // request
  logic [tclru_pkg::OP_W-1:0]  req_op_r;
  logic [ZW-1:0]               req_zoom_r;
  logic [PW-1:0]               req_col_r;
  logic [PW-1:0]               req_row_r;
  logic                        req_range_r;
  logic [tclru_pkg::SEL_W-1:0] req_sel_r;
  logic                        req_flag_r;

  logic [ZW-1:0] zoom_clamp;
  logic [PW-1:0] col_mask;
  logic          row_fits;

  // scan accumulators
  logic                            eval_vld_r;
  logic [SW-1:0]                   eval_idx_r;
  logic                            hit_r, hit_ready_r, hit_loading_r;
  logic [SW-1:0]                   hit_idx_r;
  logic                            inv_found_r;
  logic [SW-1:0]                   inv_idx_r;
  logic                            min_have_r, min_ready_r;
  logic [SW-1:0]                   min_idx_r;
  logic [tclru_pkg::STAMP_W-1:0]   min_stamp_r;
  logic                            p1_found_r, p2_found_r;
  logic [SW-1:0]                   p1_idx_r, p2_idx_r;

  logic [tclru_pkg::SLOT_COUNT-1:0] valid_r;
  logic [tclru_pkg::STAMP_W-1:0]    use_count_r;

  logic                      out_valid_r;
  tclru_pkg::out_item_t      out_data_r, out_data_nxt;

  // memory
  logic                      ram_we, ram_re;
  logic [SW-1:0]             ram_waddr, ram_raddr;
  tclru_pkg::entry_t         ram_wdata, ram_rdata;
  logic [SW-1:0]             sel_addr;

  // evaluation of the scanned entry
  logic          ev_valid, ev_match, ev_parent;
  logic [ZW-1:0] parent_zoom;

  // commit
  logic [SW-1:0] victim, slot_fin;
  logic          ready_fin, loading_fin, evict, search, p1_use, parent_hit;
  logic [SW-1:0] parent_idx;
  logic [tclru_pkg::STAMP_W-1:0] stamp_nxt;

  // request decode at accept
  always_comb begin
    zoom_clamp = (in_data.zoom_level > ZW'(tclru_pkg::MAX_ZOOM)) ?
                 ZW'(tclru_pkg::MAX_ZOOM) : in_data.zoom_level;
    col_mask   = ~({PW{1'b1}} << zoom_clamp);
    row_fits   = !in_data.tile_row[tclru_pkg::COORD_W-1] &&
                 ((in_data.tile_row >> zoom_clamp) == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op_r    <= in_data.opcode;
      req_zoom_r  <= zoom_clamp;
      req_col_r   <= in_data.tile_col[PW-1:0] & col_mask;
      req_row_r   <= in_data.tile_row[PW-1:0];
      req_range_r <= row_fits;
      req_sel_r   <= in_data.slot_sel;
      req_flag_r  <= in_data.flag_value;
    end
  end

  assign sel_addr = SW'(req_sel_r);

  assign status.op       = req_op_r;
  assign status.in_range = req_range_r;
  assign status.sel_ok   = (32'(req_sel_r) < tclru_pkg::SLOT_COUNT);
  assign status.out_free = !out_valid_r || out_ready;

  // entry store
  tclru_ram #(
    .WIDTH (tclru_pkg::ENTRY_W),
    .DEPTH (tclru_pkg::SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_re    = cmd.scan_rd | cmd.set_rd;
  assign ram_raddr = cmd.scan_rd ? cmd.scan_idx : sel_addr;

  // scan evaluation, one entry per cycle behind the read
  assign parent_zoom = req_zoom_r - 1'b1;
  assign ev_valid    = valid_r[eval_idx_r];
  assign ev_match    = ev_valid && ram_rdata.zoom == req_zoom_r &&
                       ram_rdata.col == req_col_r && ram_rdata.row == req_row_r;
  assign ev_parent   = ev_valid && ram_rdata.ready && ram_rdata.zoom == parent_zoom &&
                       ram_rdata.col == (req_col_r >> 1) &&
                       ram_rdata.row == (req_row_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_vld_r <= 1'b0;
    end else begin
      eval_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= cmd.scan_idx;
    if (cmd.scan_clear) begin
      hit_r       <= 1'b0;
      inv_found_r <= 1'b0;
      min_have_r  <= 1'b0;
      p1_found_r  <= 1'b0;
      p2_found_r  <= 1'b0;
    end else if (eval_vld_r) begin
      if (ev_match && !hit_r) begin
        hit_r         <= 1'b1;
        hit_idx_r     <= eval_idx_r;
        hit_ready_r   <= ram_rdata.ready;
        hit_loading_r <= ram_rdata.loading;
      end
      // keep the last free slot
      if (!ev_valid) begin
        inv_found_r <= 1'b1;
        inv_idx_r   <= eval_idx_r;
      end
      // strict compare: lowest slot wins a tie
      if (!min_have_r || ram_rdata.stamp < min_stamp_r) begin
        min_have_r  <= 1'b1;
        min_stamp_r <= ram_rdata.stamp;
        min_idx_r   <= eval_idx_r;
        min_ready_r <= ram_rdata.ready;
      end
      // keep two candidates: the first may be the slot we refill
      if (ev_parent) begin
        if (!p1_found_r) begin
          p1_found_r <= 1'b1;
          p1_idx_r   <= eval_idx_r;
        end else if (!p2_found_r) begin
          p2_found_r <= 1'b1;
          p2_idx_r   <= eval_idx_r;
        end
      end
    end
  end

  // lookup commit
  always_comb begin
    victim      = inv_found_r ? inv_idx_r : min_idx_r;
    slot_fin    = hit_r ? hit_idx_r : victim;
    ready_fin   = hit_r && hit_ready_r;
    loading_fin = hit_r && hit_loading_r;
    evict       = !hit_r && !inv_found_r && min_ready_r;
    search      = !ready_fin && (req_zoom_r != '0);
    p1_use      = p1_found_r && (hit_r || p1_idx_r != victim);
    parent_hit  = search && (p1_use || p2_found_r);
    parent_idx  = p1_use ? p1_idx_r : p2_idx_r;
    stamp_nxt   = use_count_r + 1'b1;
  end

  always_comb begin
    ram_we    = cmd.commit_lookup | cmd.commit_set;
    ram_waddr = cmd.commit_lookup ? slot_fin : sel_addr;
    ram_wdata = ram_rdata;
    if (cmd.commit_lookup) begin
      ram_wdata.zoom    = req_zoom_r;
      ram_wdata.col     = req_col_r;
      ram_wdata.row     = req_row_r;
      ram_wdata.ready   = ready_fin;
      ram_wdata.loading = loading_fin;
      ram_wdata.stamp   = stamp_nxt;
    end else if (req_op_r == tclru_pkg::OP_SET_READY) begin
      ram_wdata.ready   = req_flag_r;
    end else begin
      ram_wdata.loading = req_flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      use_count_r <= '0;
    end else if (cmd.commit_lookup) begin
      valid_r[slot_fin] <= 1'b1;
      use_count_r       <= stamp_nxt;
    end
  end

  // result register
  always_comb begin
    out_data_nxt = '0;
    priority if (cmd.commit_lookup) begin
      out_data_nxt.in_range      = 1'b1;
      out_data_nxt.hit           = hit_r;
      out_data_nxt.slot          = tclru_pkg::SEL_W'(slot_fin);
      out_data_nxt.evict_ready   = evict;
      out_data_nxt.entry_ready   = ready_fin;
      out_data_nxt.entry_loading = loading_fin;
      out_data_nxt.parent_hit    = parent_hit;
      out_data_nxt.parent_slot   = parent_hit ? tclru_pkg::SEL_W'(parent_idx) : '0;
    end else if (cmd.commit_set) begin
      out_data_nxt.slot          = req_sel_r;
      out_data_nxt.entry_ready   = ram_wdata.ready;
      out_data_nxt.entry_loading = ram_wdata.loading;
    end else if (req_op_r == tclru_pkg::OP_SET_READY ||
                 req_op_r == tclru_pkg::OP_SET_LOADING) begin
      // set on a slot beyond the cache: echo the slot only
      out_data_nxt.slot = req_sel_r;
    end else begin
      out_data_nxt.slot = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit_lookup || cmd.commit_set || cmd.commit_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_lookup || cmd.commit_set || cmd.commit_empty) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tclru_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // copies of the cache state: one checks results, one steers the stimulus
  localparam int CHK = 0;
  localparam int GEN = 1;

  localparam int PHASE_ITEMS      = 200;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int DRAIN_CYCLES     = 100;
  localparam int RECENT_KEYS      = 96;
  localparam int MAX_PRINTS       = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  tile_cache_lru_lookup_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  logic               tc_valid   [2][SLOT_COUNT];
  logic [ZOOM_W-1:0]  tc_zoom    [2][SLOT_COUNT];
  logic [POS_W-1:0]   tc_col     [2][SLOT_COUNT];
  logic [POS_W-1:0]   tc_row     [2][SLOT_COUNT];
  logic               tc_ready   [2][SLOT_COUNT];
  logic               tc_loading [2][SLOT_COUNT];
  logic [STAMP_W-1:0] tc_stamp   [2][SLOT_COUNT];
  logic [STAMP_W-1:0] tc_uses    [2];

  in_item_t  op_queue[$];
  out_item_t expected_results[$];
  out_item_t want_res;

  int key_z[$];
  int key_c[$];
  int key_r[$];
  int last_slot = 0;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic recv_hold = 1'b0;
  int   mismatch_count = 0;
  int   result_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one operation to state copy k and return the result it produces.
  function automatic out_item_t tile_cache_step(input int k, input in_item_t it);
    out_item_t          r;
    int                 z, i, found;
    longint             col, row, n, cm;
    logic [POS_W-1:0]   wc, wr;
    logic [STAMP_W-1:0] min_stamp;
    bit                 have_min;
    r = '0;
    found = -1;
    have_min = 1'b0;
    min_stamp = '0;
    if (it.opcode == OP_SET_READY || it.opcode == OP_SET_LOADING) begin
      r.slot = it.slot_sel;
      if (int'(it.slot_sel) < SLOT_COUNT) begin
        if (it.opcode == OP_SET_READY)
          tc_ready[k][it.slot_sel] = it.flag_value;
        else
          tc_loading[k][it.slot_sel] = it.flag_value;
        r.entry_ready   = tc_ready[k][it.slot_sel];
        r.entry_loading = tc_loading[k][it.slot_sel];
      end
      return r;
    end
    if (it.opcode != OP_LOOKUP)
      return r;
    z = (int'(it.zoom_level) > MAX_ZOOM) ? MAX_ZOOM : int'(it.zoom_level);
    col = longint'(it.tile_col);
    row = longint'(it.tile_row);
    n = longint'(1) << z;
    if (row < 0 || row >= n)
      return r;
    r.in_range = 1'b1;
    cm = col & (n - 1);
    wc = cm[POS_W-1:0];
    wr = row[POS_W-1:0];
    for (i = 0; i < SLOT_COUNT; i++) begin
      if (found < 0 && tc_valid[k][i] && tc_zoom[k][i] == z &&
          tc_col[k][i] == wc && tc_row[k][i] == wr)
        found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
    end else begin
      // last free slot, else oldest stamp with the lowest slot on a tie
      for (i = 0; i < SLOT_COUNT; i++) begin
        if (!tc_valid[k][i])
          found = i;
      end
      if (found < 0) begin
        for (i = 0; i < SLOT_COUNT; i++) begin
          if (!have_min || tc_stamp[k][i] < min_stamp) begin
            have_min = 1'b1;
            min_stamp = tc_stamp[k][i];
            found = i;
          end
        end
      end
      r.evict_ready = tc_valid[k][found] && tc_ready[k][found];
      tc_valid[k][found]   = 1'b1;
      tc_zoom[k][found]    = z[ZOOM_W-1:0];
      tc_col[k][found]     = wc;
      tc_row[k][found]     = wr;
      tc_ready[k][found]   = 1'b0;
      tc_loading[k][found] = 1'b0;
    end
    tc_uses[k] = tc_uses[k] + 1;
    tc_stamp[k][found] = tc_uses[k];
    r.slot          = found[SEL_W-1:0];
    r.entry_ready   = tc_ready[k][found];
    r.entry_loading = tc_loading[k][found];
    if (!tc_ready[k][found] && z > 0) begin
      for (i = 0; i < SLOT_COUNT; i++) begin
        if (!r.parent_hit && tc_valid[k][i] && tc_zoom[k][i] == z - 1 &&
            tc_col[k][i] == (wc >> 1) && tc_row[k][i] == (wr >> 1) &&
            tc_ready[k][i]) begin
          r.parent_hit  = 1'b1;
          r.parent_slot = i[SEL_W-1:0];
        end
      end
    end
    return r;
  endfunction

  function automatic in_item_t lookup_item(input int z, input int c, input int r);
    in_item_t    it;
    logic [31:0] rnd;
    rnd = $urandom;
    it.opcode     = OP_LOOKUP;
    it.zoom_level = z[ZOOM_W-1:0];
    it.tile_col   = c[COORD_W-1:0];
    it.tile_row   = r[COORD_W-1:0];
    it.slot_sel   = rnd[SEL_W-1:0];
    it.flag_value = rnd[SEL_W];
    return it;
  endfunction

  function automatic in_item_t flag_item(input logic [OP_W-1:0] op, input int s,
                                         input logic v);
    in_item_t it;
    it = lookup_item($urandom_range(31), $urandom, $urandom);
    it.opcode     = op;
    it.slot_sel   = s[SEL_W-1:0];
    it.flag_value = v;
    return it;
  endfunction

  task automatic queue_op(input in_item_t it);
    out_item_t r;
    int        s, i, j;
    if (it.opcode == OP_SET_READY || it.opcode == OP_SET_LOADING) begin
      // flags of a never-filled slot are undefined: move the write to a filled slot
      if (!tc_valid[GEN][it.slot_sel]) begin
        s = -1;
        for (i = 0; i < SLOT_COUNT; i++) begin
          j = (int'(it.slot_sel) + i) % SLOT_COUNT;
          if (s < 0 && tc_valid[GEN][j])
            s = j;
        end
        if (s < 0)
          it.opcode = OP_LOOKUP;
        else
          it.slot_sel = s[SEL_W-1:0];
      end
    end
    r = tile_cache_step(GEN, it);
    if (it.opcode == OP_LOOKUP && r.in_range) begin
      last_slot = int'(r.slot);
      key_z.push_back(int'(tc_zoom[GEN][r.slot]));
      key_c.push_back(int'(tc_col[GEN][r.slot]));
      key_r.push_back(int'(tc_row[GEN][r.slot]));
      if (key_z.size() > RECENT_KEYS) begin
        void'(key_z.pop_front());
        void'(key_c.pop_front());
        void'(key_r.pop_front());
      end
    end
    op_queue.push_back(it);
  endtask

  task automatic queue_random_op();
    in_item_t    it;
    logic [31:0] rnd;
    int          pick, idx, z, zc, c, r, s;
    pick = $urandom_range(99);
    idx = (key_z.size() > 0) ? $urandom_range(key_z.size() - 1) : 0;
    s = ($urandom_range(1) == 1) ? last_slot : $urandom_range(SLOT_COUNT - 1);
    if (pick < 12) begin
      it = flag_item(OP_SET_READY, s, $urandom_range(3) != 0);
    end else if (pick < 18) begin
      it = flag_item(OP_SET_LOADING, s, $urandom_range(1) != 0);
    end else if (pick < 20) begin
      it = flag_item(OP_UNUSED, $urandom_range(63), $urandom_range(1) != 0);
    end else if (pick < 25) begin
      // noise: every field but the opcode random, rows mostly out of range
      it = lookup_item($urandom_range(31), $urandom, $urandom);
    end else if (pick < 60 && key_z.size() > 0) begin
      // revisit a recent tile, column shifted by at most one whole turn either way
      z = key_z[idx];
      c = key_c[idx] + (int'($urandom_range(2)) - 1) * (1 << z);
      r = key_r[idx];
      if (z == MAX_ZOOM && $urandom_range(1) == 1)
        z = $urandom_range(31, MAX_ZOOM);
      it = lookup_item(z, c, r);
    end else if (pick < 80 && key_z.size() > 0 && key_z[idx] < MAX_ZOOM) begin
      z = key_z[idx] + 1;
      c = 2 * key_c[idx] + int'($urandom_range(1));
      r = 2 * key_r[idx] + int'($urandom_range(1));
      it = lookup_item(z, c, r);
    end else begin
      z = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(6);
      zc = (z > MAX_ZOOM) ? MAX_ZOOM : z;
      rnd = $urandom;
      c = int'($signed(rnd[COORD_W-1:0]));
      r = $urandom_range((1 << zc) - 1);
      it = lookup_item(z, c, r);
    end
    queue_op(it);
  endtask

  task automatic wait_for_drain();
    while (op_queue.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS)
      $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                result_count, field, got, want));
  endtask

  // driver: predict on each transfer, then offer the next pending item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(tile_cache_step(CHK, in_data));
      if (!in_valid || in_ready) begin
        if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= op_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", result_count));
        end else begin
          want_res = expected_results.pop_front();
          check_field("in_range", int'(out_data.in_range), int'(want_res.in_range));
          check_field("hit", int'(out_data.hit), int'(want_res.hit));
          check_field("slot", int'(out_data.slot), int'(want_res.slot));
          check_field("evict_ready", int'(out_data.evict_ready),
                      int'(want_res.evict_ready));
          check_field("entry_ready", int'(out_data.entry_ready),
                      int'(want_res.entry_ready));
          check_field("entry_loading", int'(out_data.entry_loading),
                      int'(want_res.entry_loading));
          check_field("parent_hit", int'(out_data.parent_hit),
                      int'(want_res.parent_hit));
          check_field("parent_slot", int'(out_data.parent_slot),
                      int'(want_res.parent_slot));
        end
        result_count++;
      end
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off early on, so the block backs up and stalls its input
  initial begin
    @(posedge rst_n);
    repeat (10) @(posedge clk);
    recv_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    recv_hold <= 1'b0;
  end

  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int k, i, p;
    for (k = 0; k < 2; k++) begin
      tc_uses[k] = '0;
      for (i = 0; i < SLOT_COUNT; i++) begin
        tc_valid[k][i]   = 1'b0;
        tc_zoom[k][i]    = '0;
        tc_col[k][i]     = '0;
        tc_row[k][i]     = '0;
        tc_ready[k][i]   = 1'b0;
        tc_loading[k][i] = 1'b0;
        tc_stamp[k][i]   = '0;
      end
    end

    queue_op(lookup_item(0, 0, 0));
    queue_op(lookup_item(0, 0, 0));
    queue_op(lookup_item(0, -262144, 0));
    queue_op(lookup_item(0, 0, 1));
    queue_op(lookup_item(0, 0, -1));
    // zoom above the limit clamps; column wraps to the top of the level
    queue_op(lookup_item(31, 524287, 262143));
    queue_op(lookup_item(18, -1, 262143));
    queue_op(lookup_item(18, 0, 262144));
    queue_op(lookup_item(18, 0, 524287));
    queue_op(lookup_item(5, 0, -262144));
    queue_op(lookup_item(18, -524288, 0));
    queue_op(flag_item(OP_UNUSED, 63, 1'b1));
    queue_op(flag_item(OP_SET_READY, 63, 1'b1));
    // child of a ready root finds its parent
    queue_op(lookup_item(1, 1, 1));
    queue_op(flag_item(OP_SET_READY, 60, 1'b1));
    // hit on a ready entry skips the parent search
    queue_op(lookup_item(1, 3, 1));
    queue_op(flag_item(OP_SET_LOADING, 60, 1'b1));
    queue_op(flag_item(OP_SET_LOADING, 60, 1'b0));
    queue_op(flag_item(OP_SET_READY, 63, 1'b0));
    queue_op(lookup_item(1, 0, 0));
    queue_op(flag_item(OP_SET_LOADING, 59, 1'b1));
    queue_op(lookup_item(2, 2, 3));
    queue_op(flag_item(OP_SET_READY, 61, 1'b1));
    queue_op(lookup_item(19, 524287, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait_for_drain();

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 88;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 88;
        end
        default: begin
          send_idle_pct  <= 10;
          recv_stall_pct <= 10;
        end
      endcase
      repeat (PHASE_ITEMS) queue_random_op();
      // hold the sender until every result of the phase is back
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
